// ===== hw/rtl/sfcc_pkg.sv =====
// Shared constants, types and the CRC-8 step function for the sensor frame converter.
// No dependencies; all other files use it through scoped names.
package sfcc_pkg;

    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [7:0]         CRC_INIT    = 8'hFF;
    localparam logic signed [19:0] TEMP_BIAS   = 20'sd102400;
    localparam logic signed [26:0] CAL_SPAN    = 27'sd600;
    localparam logic signed [27:0] CAL_BASE    = 28'sd300;
    localparam logic signed [16:0] COMP_REF    = 17'sd250;
    localparam logic [32:0]        COMP_RECIP  = 33'd83887;
    localparam int                 COMP_SHIFT  = 23;
    localparam logic signed [27:0] HUM_LIMIT_S = 28'sd1000;
    localparam logic [9:0]         HUM_LIMIT   = 10'd1000;
    localparam logic [9:0]         HUM_CLIP    = 10'd999;

    localparam int QW         = 26;
    localparam int DW         = 16;
    localparam int DIV_STAGES = QW;

    localparam logic CFG_CAL_HIGH = 1'b0;
    localparam logic CFG_CAL_LOW  = 1'b1;

    typedef struct packed {
        logic              t_ok;
        logic              h_ok;
        logic              cal_bad;
        logic signed [11:0] temp;
        logic              q_neg;
        logic              comp_neg;
        logic [8:0]        comp_mag;
    } t_side;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/sfcc_front.sv =====
// Front pipeline: CRC checks, temperature conversion, humidity numerator and divisor
// setup, temperature compensation term. Depends on sfcc_pkg.
module sfcc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_valid,
    input  logic [15:0]                i_temp_word,
    input  logic [7:0]                 i_temp_check,
    input  logic [15:0]                i_hum_word,
    input  logic [7:0]                 i_hum_check,
    input  logic [15:0]                i_cal_high,
    input  logic [15:0]                i_cal_low,
    output logic                       o_valid,
    output logic [sfcc_pkg::QW-1:0]    o_num,
    output logic [sfcc_pkg::DW-1:0]    o_den,
    output sfcc_pkg::t_side            o_side
);

    // stage 1
    logic              r1_v;
    logic [7:0]        r1_tcrc, r1_hcrc, r1_tlo, r1_hlo, r1_tchk, r1_hchk;
    logic signed [16:0] r1_diff, r1_den;
    logic              r1_cal_bad;
    logic signed [19:0] r1_n;
    logic signed [19:0] n_s20;

    assign n_s20 = $signed({{4{i_temp_word[15]}}, i_temp_word});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_tcrc    <= sfcc_pkg::crc8_byte(sfcc_pkg::CRC_INIT, i_temp_word[15:8]);
            r1_hcrc    <= sfcc_pkg::crc8_byte(sfcc_pkg::CRC_INIT, i_hum_word[15:8]);
            r1_tlo     <= i_temp_word[7:0];
            r1_hlo     <= i_hum_word[7:0];
            r1_tchk    <= i_temp_check;
            r1_hchk    <= i_hum_check;
            r1_diff    <= $signed({1'b0, i_hum_word}) - $signed({1'b0, i_cal_low});
            r1_den     <= $signed({1'b0, i_cal_high}) - $signed({1'b0, i_cal_low});
            r1_cal_bad <= (i_cal_high == i_cal_low);
            r1_n       <= sfcc_pkg::TEMP_BIAS + (n_s20 <<< 3) + (n_s20 <<< 1);
        end
    end

    // stage 2
    logic               r2_v;
    sfcc_pkg::t_side    r2_side, n_2side;
    logic signed [26:0] r2_num;
    logic [15:0]        r2_den_mag;
    logic               r2_den_neg;
    logic signed [26:0] diff_x;
    logic signed [19:0] nmag;
    logic [11:0]        tmag;
    logic signed [16:0] den_abs;

    always_comb begin
        diff_x   = 27'(r1_diff);
        nmag     = r1_n[19] ? -r1_n : r1_n;
        tmag     = nmag[19:8];
        den_abs  = r1_den[16] ? -r1_den : r1_den;
        n_2side          = '0;
        n_2side.t_ok     = (sfcc_pkg::crc8_byte(r1_tcrc, r1_tlo) == r1_tchk);
        n_2side.h_ok     = (sfcc_pkg::crc8_byte(r1_hcrc, r1_hlo) == r1_hchk);
        n_2side.cal_bad  = r1_cal_bad;
        n_2side.temp     = r1_n[19] ? -$signed(tmag) : $signed(tmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_side    <= n_2side;
            r2_num     <= diff_x * sfcc_pkg::CAL_SPAN;
            r2_den_mag <= den_abs[15:0];
            r2_den_neg <= r1_den[16];
        end
    end

    // stage 3
    logic               r3_v;
    sfcc_pkg::t_side    r3_side, n_3side;
    logic [25:0]        r3_num_mag;
    logic [15:0]        r3_den_mag;
    logic signed [16:0] r3_x25;
    logic signed [26:0] num_abs;
    logic signed [16:0] xoff;

    always_comb begin
        num_abs       = r2_num[26] ? -r2_num : r2_num;
        xoff          = 17'(r2_side.temp) - sfcc_pkg::COMP_REF;
        n_3side       = r2_side;
        n_3side.q_neg = r2_num[26] ^ r2_den_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_side    <= n_3side;
            r3_num_mag <= num_abs[25:0];
            r3_den_mag <= r2_den_mag;
            r3_x25     <= (xoff <<< 4) + (xoff <<< 3) + xoff;
        end
    end

    // stage 4
    logic            r4_v;
    sfcc_pkg::t_side r4_side, n_4side;
    logic [25:0]     r4_num_mag;
    logic [15:0]     r4_den_mag;
    logic [15:0]     r4_ax;
    logic signed [16:0] x_abs;

    always_comb begin
        x_abs            = r3_x25[16] ? -r3_x25 : r3_x25;
        n_4side          = r3_side;
        n_4side.comp_neg = r3_x25[16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_side    <= n_4side;
            r4_num_mag <= r3_num_mag;
            r4_den_mag <= r3_den_mag;
            r4_ax      <= x_abs[15:0];
        end
    end

    // stage 5
    logic            r5_v;
    sfcc_pkg::t_side r5_side, n_5side;
    logic [25:0]     r5_num_mag;
    logic [15:0]     r5_den_mag;
    logic [32:0]     prod;

    always_comb begin
        prod             = 33'(r4_ax) * sfcc_pkg::COMP_RECIP;
        n_5side          = r4_side;
        n_5side.comp_mag = prod[sfcc_pkg::COMP_SHIFT+8:sfcc_pkg::COMP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_side    <= n_5side;
            r5_num_mag <= r4_num_mag;
            r5_den_mag <= r4_den_mag;
        end
    end

    assign o_valid = r5_v;
    assign o_num   = r5_num_mag;
    assign o_den   = r5_den_mag;
    assign o_side  = r5_side;

endmodule

// ===== hw/rtl/sfcc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Carries the item sideband alongside. Depends on sfcc_pkg.
module sfcc_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [sfcc_pkg::QW-1:0] i_num,
    input  logic [sfcc_pkg::DW-1:0] i_den,
    input  sfcc_pkg::t_side         i_side,
    output logic                    o_valid,
    output logic [sfcc_pkg::QW-1:0] o_quo,
    output sfcc_pkg::t_side         o_side
);

    localparam int NS = sfcc_pkg::DIV_STAGES;
    localparam int QW = sfcc_pkg::QW;
    localparam int DW = sfcc_pkg::DW;

    logic            r_v   [NS];
    logic [QW-1:0]   r_num [NS];
    logic [QW-1:0]   r_quo [NS];
    logic [DW-1:0]   r_rem [NS];
    logic [DW-1:0]   r_den [NS];
    sfcc_pkg::t_side r_side[NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic            v_in;
        logic [QW-1:0]   num_in, quo_in;
        logic [DW-1:0]   rem_in, den_in;
        sfcc_pkg::t_side side_in;
        logic [DW:0]     trial, diff;
        logic            ge;
        logic [DW-1:0]   n_rem;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign quo_in  = '0;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign num_in  = r_num[k-1];
            assign quo_in  = r_quo[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = {rem_in, num_in[QW-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[k]  <= {num_in[QW-2:0], 1'b0};
                r_quo[k]  <= {quo_in[QW-2:0], ge};
                r_rem[k]  <= n_rem;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== hw/rtl/sfcc_back.sv =====
// Back pipeline: signs the quotient, adds base and compensation, clamps, and holds
// the result register. Depends on sfcc_pkg.
module sfcc_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [sfcc_pkg::QW-1:0] i_quo,
    input  sfcc_pkg::t_side         i_side,
    output logic                    o_valid,
    output logic signed [11:0]      o_temperature,
    output logic                    o_temp_valid,
    output logic [9:0]              o_humidity,
    output logic                    o_hum_valid,
    output logic                    o_crc_error,
    output logic                    o_cal_error
);

    // stage 1: signed sum
    logic               r1_v;
    sfcc_pkg::t_side    r1_side;
    logic signed [27:0] r1_h;
    logic signed [27:0] sq, sc;

    always_comb begin
        sq = i_side.q_neg ? -$signed(28'(i_quo)) : $signed(28'(i_quo));
        sc = i_side.comp_neg ? -$signed(28'(i_side.comp_mag)) : $signed(28'(i_side.comp_mag));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_side <= i_side;
            r1_h    <= sq + sfcc_pkg::CAL_BASE + sc;
        end
    end

    // stage 2: clamp, qualify, result register
    logic               r2_v;
    logic signed [11:0] r2_temp;
    logic               r2_t_ok, r2_hum_ok, r2_crc_err, r2_cal_err;
    logic [9:0]         r2_hum;
    logic [9:0]         hclamp;
    logic               hum_ok;

    always_comb begin
        hum_ok = r1_side.t_ok & r1_side.h_ok & ~r1_side.cal_bad;
        if (r1_h > sfcc_pkg::HUM_LIMIT_S) begin
            hclamp = sfcc_pkg::HUM_CLIP;
        end else if (r1_h[27]) begin
            hclamp = '0;
        end else begin
            hclamp = r1_h[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_temp    <= r1_side.t_ok ? r1_side.temp : '0;
            r2_t_ok    <= r1_side.t_ok;
            r2_hum     <= hum_ok ? hclamp : '0;
            r2_hum_ok  <= hum_ok;
            r2_crc_err <= ~(r1_side.t_ok & r1_side.h_ok);
            r2_cal_err <= r1_side.cal_bad;
        end
    end

    assign o_valid       = r2_v;
    assign o_temperature = r2_temp;
    assign o_temp_valid  = r2_t_ok;
    assign o_humidity    = r2_hum;
    assign o_hum_valid   = r2_hum_ok;
    assign o_crc_error   = r2_crc_err;
    assign o_cal_error   = r2_cal_err;

endmodule

// ===== hw/rtl/sensor_frame_crc_convert_top.sv =====
// Top level of the sensor frame CRC check and conversion pipeline.
// Depends on sfcc_pkg, sfcc_front, sfcc_div and sfcc_back.
//
//   channel  direction  handshake                    content
//   s_axis   in         i_s_axis_tvalid/o_s_axis_tready   one frame (two words, two CRC bytes)
//   m_axis   out        o_m_axis_tvalid/i_m_axis_tready   temperature, humidity, status flags
//   cfg      in         i_cfg_valid/o_cfg_ready           calibration register write
//
// One frame per cycle while m_axis is not stalled; 5 front stages, 26 divider stages
// and 2 back stages, the divider producing one quotient bit per stage.
// Synchronous active-low reset clears all stage valid bits and both calibration words.
// A stall on m_axis freezes every stage together; s_axis is refused only while the
// result register is full and not being taken.
// Configuration writes are always accepted.
module sensor_frame_crc_convert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // temp_word[15:0], temp_check[23:16], hum_word[39:24], hum_check[47:40]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // temperature[11:0], humidity[21:12], zero[23:22]
    output logic [3:0]  o_m_axis_tuser,  // temp_valid[0], hum_valid[1], crc_error[2], cal_error[3]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_cal_high, r_cal_low;
    logic        adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_high <= '0;
            r_cal_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfcc_pkg::CFG_CAL_HIGH: r_cal_high <= i_cfg_data;
                sfcc_pkg::CFG_CAL_LOW:  r_cal_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign adv             = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = adv;

    logic                    f_valid;
    logic [sfcc_pkg::QW-1:0] f_num;
    logic [sfcc_pkg::DW-1:0] f_den;
    sfcc_pkg::t_side         f_side;

    sfcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_s_axis_tvalid),
        .i_temp_word  (i_s_axis_tdata[15:0]),
        .i_temp_check (i_s_axis_tdata[23:16]),
        .i_hum_word   (i_s_axis_tdata[39:24]),
        .i_hum_check  (i_s_axis_tdata[47:40]),
        .i_cal_high   (r_cal_high),
        .i_cal_low    (r_cal_low),
        .o_valid      (f_valid),
        .o_num        (f_num),
        .o_den        (f_den),
        .o_side       (f_side)
    );

    logic                    d_valid;
    logic [sfcc_pkg::QW-1:0] d_quo;
    sfcc_pkg::t_side         d_side;

    sfcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    logic               temp_valid, hum_valid, crc_error, cal_error;

    sfcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (d_valid),
        .i_quo         (d_quo),
        .i_side        (d_side),
        .o_valid       (o_m_axis_tvalid),
        .o_temperature (temperature),
        .o_temp_valid  (temp_valid),
        .o_humidity    (humidity),
        .o_hum_valid   (hum_valid),
        .o_crc_error   (crc_error),
        .o_cal_error   (cal_error)
    );

    assign o_m_axis_tdata = {2'b00, humidity, temperature};
    assign o_m_axis_tuser = {cal_error, crc_error, hum_valid, temp_valid};

    a_hum_needs_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && hum_valid) |-> (temp_valid && !crc_error && !cal_error))
        else $error("humidity marked valid without good CRCs and calibration");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (humidity <= sfcc_pkg::HUM_LIMIT))
        else $error("humidity above limit");

    a_bad_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !temp_valid) |-> (temperature == 12'sd0 && crc_error))
        else $error("bad temperature CRC not reported");

endmodule
